[sv/histogram_equalizer_defines.svh]
// Assertion macros used by the histogram equalizer engine (he_back).
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH
`ifndef ASSERT_OFF
// a implies b in the same cycle
`define HE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a implies b in the next cycle
`define HE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define HE_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define HE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[sv/he_pkg.sv]
`timescale 1ns / 1ps
package he_pkg;
    localparam int GRAY_LEVELS = 256;
    localparam int COUNT_BITS  = 24;
    localparam int BIN_BITS    = $clog2(GRAY_LEVELS);
    localparam int CDF_BITS    = COUNT_BITS + BIN_BITS;
    localparam int NUM_BITS    = CDF_BITS + BIN_BITS;
    localparam int Q_BITS      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ACC   = 2'd1;
    localparam logic [1:0] FUNC_MAP   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       no_data;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ACC,
        CMD_MAP
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t     cmd;
        logic [7:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t item;
    } queue_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_WR,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_RESULT
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : v + 1'b1;
        return r;
    endfunction
endpackage

[sv/he_ram.sv]
`timescale 1ns / 1ps
module he_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/he_front.sv]
`timescale 1ns / 1ps
module he_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  he_pkg::in_item_t    s_data,
    output he_pkg::queue_out_t  q_out,
    input  logic                q_pop
);
    he_pkg::cmd_t mem_reg [he_pkg::QUEUE_DEPTH];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg, count_next;
    logic         keep;
    logic         push;
    he_pkg::cmd_t cls;

    // classify: drop unused codes
    always_comb begin
        cls.pixel = s_data.pixel_in;
        cls.cmd   = he_pkg::CMD_CLEAR;
        keep      = 1'b1;
        unique case (s_data.func)
            he_pkg::FUNC_CLEAR: cls.cmd = he_pkg::CMD_CLEAR;
            he_pkg::FUNC_ACC: begin
                cls.cmd = he_pkg::CMD_ACC;
                keep    = (32'(s_data.pixel_in) < he_pkg::GRAY_LEVELS);
            end
            he_pkg::FUNC_MAP: cls.cmd = he_pkg::CMD_MAP;
            default: keep = 1'b0;
        endcase
    end

    assign s_ready     = (count_reg != 2'(he_pkg::QUEUE_DEPTH));
    assign push        = s_valid && s_ready && keep;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(q_pop && q_out.valid)) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop && q_out.valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_out.valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

[sv/he_back.sv]
`timescale 1ns / 1ps
`include "histogram_equalizer_defines.svh"
module he_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  he_pkg::queue_out_t  q_in,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output he_pkg::out_item_t   m_data
);
    localparam int BB = he_pkg::BIN_BITS;
    localparam int CB = he_pkg::COUNT_BITS;
    localparam int DB = he_pkg::CDF_BITS;
    localparam int NB = he_pkg::NUM_BITS;
    localparam int QB = he_pkg::Q_BITS;

    he_pkg::state_t            state_reg, state_next;
    logic [he_pkg::GRAY_LEVELS-1:0] valid_reg, valid_next;
    logic [CB-1:0]             total_reg, total_next;
    logic [BB-1:0]             k_reg, k_next, last_reg, last_next;
    logic [BB-1:0]             acc_addr_reg, acc_addr_next;
    logic [DB-1:0]             cdf_reg, cdf_next;
    logic [NB-1:0]             rem_reg, rem_next, den_reg, den_next;
    logic [3:0]                bit_reg, bit_next;
    logic [QB-1:0]             q_reg, q_next;
    logic                      nd_reg, nd_next;
    logic                      out_valid_reg, out_valid_next;
    he_pkg::out_item_t         out_reg, out_next;
    logic [BB-1:0]             raddr, waddr;
    logic [CB-1:0]             rdata, wdata, addend;
    logic                      we, ge;

    he_ram #(.WIDTH(CB), .DEPTH(he_pkg::GRAY_LEVELS)) u_bins (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign addend = valid_reg[k_reg] ? rdata : '0;
    assign ge     = (rem_reg >= den_reg);

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        acc_addr_next  = acc_addr_reg;
        cdf_next       = cdf_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        bit_next       = bit_reg;
        q_next         = q_reg;
        nd_next        = nd_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        raddr          = k_reg + 1'b1;
        waddr          = acc_addr_reg;
        wdata          = he_pkg::sat_inc(valid_reg[acc_addr_reg] ? rdata : '0);
        we             = 1'b0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            he_pkg::ST_IDLE: begin
                raddr = q_in.item.pixel[BB-1:0];
                if (q_in.valid) begin
                    q_pop = 1'b1;
                    unique case (q_in.item.cmd)
                        he_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                            total_next = '0;
                        end
                        he_pkg::CMD_ACC: begin
                            acc_addr_next = q_in.item.pixel[BB-1:0];
                            total_next    = he_pkg::sat_inc(total_reg);
                            state_next    = he_pkg::ST_ACC_WR;
                        end
                        he_pkg::CMD_MAP: begin
                            raddr     = '0;
                            k_next    = '0;
                            cdf_next  = '0;
                            q_next    = '0;
                            last_next = q_in.item.pixel[BB-1:0];
                            if (total_reg == '0) begin
                                nd_next    = 1'b1;
                                state_next = he_pkg::ST_RESULT;
                            end else begin
                                nd_next    = 1'b0;
                                state_next = he_pkg::ST_SUM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            he_pkg::ST_ACC_WR: begin
                we                       = 1'b1;
                valid_next[acc_addr_reg] = 1'b1;
                state_next               = he_pkg::ST_IDLE;
            end
            he_pkg::ST_SUM: begin
                cdf_next = cdf_reg + DB'(addend);
                k_next   = k_reg + 1'b1;
                if (k_reg == last_reg) begin
                    state_next = he_pkg::ST_PREP;
                end
            end
            he_pkg::ST_PREP: begin
                // scale by levels minus one: shift up, subtract once
                rem_next   = (NB'(cdf_reg) << BB) - NB'(cdf_reg);
                den_next   = NB'(total_reg) << BB;
                bit_next   = 4'(QB);
                state_next = he_pkg::ST_DIV;
            end
            he_pkg::ST_DIV: begin
                den_next = den_reg >> 1;
                if (bit_reg == 4'(QB)) begin
                    bit_next = bit_reg - 4'd1;
                    if (ge) begin
                        q_next     = '1;
                        state_next = he_pkg::ST_RESULT;
                    end
                end else begin
                    if (ge) begin
                        rem_next = rem_reg - den_reg;
                    end
                    q_next   = {q_reg[QB-2:0], ge};
                    bit_next = bit_reg - 4'd1;
                    if (bit_reg == 4'd0) begin
                        state_next = he_pkg::ST_RESULT;
                    end
                end
            end
            he_pkg::ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next     = 1'b1;
                    out_next.pixel_out = q_reg;
                    out_next.no_data   = nd_reg;
                    state_next         = he_pkg::ST_IDLE;
                end
            end
            default: state_next = he_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= he_pkg::ST_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        last_reg     <= last_next;
        acc_addr_reg <= acc_addr_next;
        cdf_reg      <= cdf_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        bit_reg      <= bit_next;
        q_reg        <= q_next;
        nd_reg       <= nd_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `HE_ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_valid && m_data.no_data, m_data.pixel_out == '0)
    `HE_ASSERT_NEXT(a_load_from_result, aclk, aresetn, (state_reg != he_pkg::ST_RESULT) && !(m_valid && !m_ready), !m_valid || $past(m_valid))
    `HE_ASSERT_IMPLY(a_pop_only_idle, aclk, aresetn, q_pop, state_reg == he_pkg::ST_IDLE)
endmodule

[sv/histogram_equalizer.sv]
`timescale 1ns / 1ps
// Histogram equalizer for 8-bit grayscale pixels.
// Input channel s_valid/s_ready/s_data carries one request: func and pixel_in.
//   func clear zeroes all 256 bins and the pixel count; accumulate adds the
//   pixel to its bin and to the count (both saturate); map returns
//   floor(255 * cdf(pixel_in) / count) on m_valid/m_ready/m_data.
//   Unused func codes are taken and dropped without a result.
// A two-entry request queue sits between the intake and the engine, so
// requests keep flowing in while the engine is busy or a result waits.
// Steps per request in the engine (the bin memory has a registered read port
//   and a separate write port): clear is applied as it is popped;
//   accumulate reads the bin, then writes it back; map with an empty
//   histogram goes straight to the result step; otherwise a sweep over bins
//   0 to pixel_in (one memory read per bin), a scaling step, up to 9
//   restoring division steps and the result step.
// A request taken by the queue reaches an idle engine in the next cycle.
// Reset: synchronous, active low; the bin valid flags and count clear at once,
//   no memory sweep is needed, and s_ready is high once reset is released.
// A stalled receiver holds m_data; the engine then waits in its result step
//   with the next result while the queue fills and s_ready drops.
module histogram_equalizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  he_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output he_pkg::out_item_t m_data
);
    he_pkg::queue_out_t q_out;
    logic               q_pop;

    // intake: classify and hold requests
    he_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_out   (q_out),
        .q_pop   (q_pop)
    );

    // engine: bin updates, cdf sweep, divide, result register
    he_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_in    (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule
